// ===== rtl/core/bbc_pkg.sv =====
// bbc_pkg: shared types and codes for the clipped box blur unit
// no dependencies
`timescale 1ns / 1ps

package bbc_pkg;

   // sequencer states, one-hot
   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_SCAN  = 6'b000010,
      ST_DRAIN = 6'b000100,
      ST_FEED  = 6'b001000,
      ST_DIV   = 6'b010000,
      ST_OUT   = 6'b100000
   } state_type;

   // configuration register indexes
   localparam logic [1:0] CSR_IMAGE_WIDTH   = 2'd0;
   localparam logic [1:0] CSR_IMAGE_HEIGHT  = 2'd1;
   localparam logic [1:0] CSR_CHANNEL_COUNT = 2'd2;

   localparam int SAMPLE_W = 8;

endpackage

// ===== rtl/core/bbc_div_cell.sv =====
// bbc_div_cell: one restoring-division step, registered
// uses bbc_pkg; chained by the top level to form the divider
`timescale 1ns / 1ps

module bbc_div_cell
   import bbc_pkg::*;
#(
   parameter int SUM_W = 14,
   parameter int CNT_W = 5
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             in_valid,
   input  logic [SUM_W-1:0] in_num,
   input  logic [CNT_W-1:0] in_rem,
   input  logic [CNT_W-1:0] in_div,
   output logic             out_valid,
   output logic [SUM_W-1:0] out_num,
   output logic [CNT_W-1:0] out_rem,
   output logic [CNT_W-1:0] out_div
);

   logic [CNT_W:0]   shifted;
   logic             ge;
   logic [CNT_W:0]   diff;
   logic             valid_ff, valid_in;
   logic [SUM_W-1:0] num_ff, num_in;
   logic [CNT_W-1:0] rem_ff, rem_in;
   logic [CNT_W-1:0] div_ff;

   // shift in next dividend bit, subtract divisor when it fits
   always_comb begin
      shifted  = {in_rem, in_num[SUM_W-1]};
      ge       = shifted >= {1'b0, in_div};
      diff     = shifted - {1'b0, in_div};
      rem_in   = ge ? diff[CNT_W-1:0] : shifted[CNT_W-1:0];
      num_in   = {in_num[SUM_W-2:0], ge};
      valid_in = in_valid;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      num_ff <= num_in;
      rem_ff <= rem_in;
      div_ff <= in_div;
   end

   assign out_valid = valid_ff;
   assign out_num   = num_ff;
   assign out_rem   = rem_ff;
   assign out_div   = div_ff;

endmodule

// ===== rtl/core/box_blur_5x5_clipped_unit.sv =====
// box_blur_5x5_clipped_unit: streaming clipped box blur over interleaved samples
// uses bbc_pkg and bbc_div_cell (chain of restoring-division cells)
`timescale 1ns / 1ps

// Each accepted item that yields no result leaves the input ready for the next one. An
// item that yields a result passes through its own transfer, the window reads through the
// single read port of the row store, the drain and feed states, the division chain
// ($clog2((2*RADIUS+1)^2*255+1) stages) and the result transfer. The input stays blocked
// until the result transfer, so any stall on the result side keeps it blocked longer.
// The row store holds 3*RADIUS+1 rows and needs no clearing.
// Results lag the input by RADIUS rows and RADIUS pixels; padding items drain the tail.
module box_blur_5x5_clipped_unit
   import bbc_pkg::*;
#(
   parameter int MAX_WIDTH    = 1024,
   parameter int MAX_CHANNELS = 4,
   parameter int RADIUS       = 2
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_sample,
   input  logic        req_is_padding,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [7:0]  rsp_blurred,
   output logic        rsp_frame_last,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_data
);

   localparam int RING   = 3 * RADIUS + 1;
   localparam int SLOT_W = $clog2(RING);
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int W_W    = $clog2(MAX_WIDTH + 1);
   localparam int CH_W   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
   localparam int CHC_W  = $clog2(MAX_CHANNELS + 1);
   localparam int DEPTH  = RING * MAX_WIDTH * MAX_CHANNELS;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int WIN    = 2 * RADIUS + 1;
   localparam int WIN_W  = $clog2(WIN + 1);
   localparam int NWIN   = WIN * WIN;
   localparam int CNT_W  = $clog2(NWIN + 1);
   localparam int SUM_W  = $clog2(NWIN * 255 + 1);
   localparam int LAG_W  = $clog2((RADIUS * MAX_WIDTH + RADIUS) * MAX_CHANNELS + 2);

   state_type state_ff, state_in;

   logic [10:0] image_width_ff;
   logic [15:0] image_height_ff;
   logic [2:0]  channel_count_ff;

   logic [W_W-1:0]   ew;
   logic [15:0]      eh;
   logic [CHC_W-1:0] ec;
   logic [LAG_W-1:0] lag;

   logic [COL_W-1:0]  in_col_ff, out_col_ff;
   logic [15:0]       in_row_ff, out_row_ff;
   logic [CH_W-1:0]   in_ch_ff, out_ch_ff;
   logic [SLOT_W-1:0] in_slot_ff, out_slot_ff;
   logic [LAG_W-1:0]  pending_ff;
   logic              last_ff;

   logic [SAMPLE_W-1:0] mem [DEPTH];
   logic [SAMPLE_W-1:0] rd_data_ff;
   logic [ADDR_W-1:0]   wr_addr, rd_addr;
   logic                we;

   logic [WIN_W-1:0] dy_ff, dx_ff;
   logic             rv_ff, acc_ff, rd_valid;
   logic [SUM_W-1:0] sum_ff;
   logic [CNT_W-1:0] cnt_ff;

   logic [7:0] blurred_ff;
   logic       frame_last_ff;

   logic accept, cfg_write, in_done, stored, emit, out_last;
   logic [LAG_W-1:0] pend_next;

   // effective register values
   always_comb begin
      if (image_width_ff == 11'd0) begin
         ew = W_W'(1);
      end else if (32'(image_width_ff) > MAX_WIDTH) begin
         ew = W_W'(MAX_WIDTH);
      end else begin
         ew = W_W'(image_width_ff);
      end
      eh = (image_height_ff == 16'd0) ? 16'd1 : image_height_ff;
      if (channel_count_ff == 3'd0) begin
         ec = CHC_W'(1);
      end else if (32'(channel_count_ff) > MAX_CHANNELS) begin
         ec = CHC_W'(MAX_CHANNELS);
      end else begin
         ec = CHC_W'(channel_count_ff);
      end
      lag = LAG_W'((RADIUS * 32'(ew) + RADIUS) * 32'(ec));
   end

   // input transfer decision
   assign req_ready = (state_ff == ST_IDLE);
   assign csr_ready = 1'b1;
   assign accept    = req_valid && req_ready;
   assign cfg_write = csr_valid && csr_ready
                      && (csr_index == CSR_IMAGE_WIDTH || csr_index == CSR_IMAGE_HEIGHT
                          || csr_index == CSR_CHANNEL_COUNT);
   assign in_done   = in_row_ff >= eh;
   assign stored    = !req_is_padding && !in_done;
   assign pend_next = pending_ff + LAG_W'(stored);
   assign emit      = (pend_next > lag) || (!stored && in_done && pend_next != '0);
   assign out_last  = (out_row_ff == eh - 16'd1) && (W_W'(out_col_ff) == ew - W_W'(1))
                      && (CHC_W'(out_ch_ff) == ec - CHC_W'(1));
   assign we        = accept && stored;
   assign wr_addr   = ADDR_W'((32'(in_slot_ff) * MAX_WIDTH + 32'(in_col_ff)) * MAX_CHANNELS
                              + 32'(in_ch_ff));

   // window read address and clipping
   always_comb begin
      logic [16:0] nrow;
      logic [W_W:0] ncol;
      int t;
      nrow = {1'b0, out_row_ff} + 17'(dy_ff);
      ncol = (W_W+1)'(out_col_ff) + (W_W+1)'(dx_ff);
      rd_valid = (nrow >= 17'(RADIUS)) && (nrow - 17'(RADIUS) < {1'b0, eh})
                 && (ncol >= (W_W+1)'(RADIUS)) && (ncol - (W_W+1)'(RADIUS) < {1'b0, ew});
      t = 32'(out_slot_ff) + RING + 32'(dy_ff) - RADIUS;
      if (t >= 2 * RING) begin
         t = t - 2 * RING;
      end else if (t >= RING) begin
         t = t - RING;
      end
      rd_addr = ADDR_W'((t * MAX_WIDTH + 32'(COL_W'(ncol - (W_W+1)'(RADIUS)))) * MAX_CHANNELS
                        + 32'(out_ch_ff));
   end

   // row store
   always_ff @(posedge clock) begin
      if (we) begin
         mem[wr_addr] <= req_sample;
      end
      rd_data_ff <= mem[rd_addr];
   end

   // division chain
   logic             dv [SUM_W+1];
   logic [SUM_W-1:0] dn [SUM_W+1];
   logic [CNT_W-1:0] dr [SUM_W+1];
   logic [CNT_W-1:0] dd [SUM_W+1];

   assign dv[0] = (state_ff == ST_FEED);
   assign dn[0] = sum_ff;
   assign dr[0] = '0;
   assign dd[0] = cnt_ff;

   for (genvar g = 0; g < SUM_W; g++) begin : g_div
      bbc_div_cell #(.SUM_W(SUM_W), .CNT_W(CNT_W)) u_cell (
         .clock    (clock),
         .reset    (reset),
         .in_valid (dv[g]),
         .in_num   (dn[g]),
         .in_rem   (dr[g]),
         .in_div   (dd[g]),
         .out_valid(dv[g+1]),
         .out_num  (dn[g+1]),
         .out_rem  (dr[g+1]),
         .out_div  (dd[g+1])
      );
   end

   // sequencer next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:  if (accept && emit) state_in = ST_SCAN;
         ST_SCAN:  if (dy_ff == WIN_W'(WIN - 1) && dx_ff == WIN_W'(WIN - 1)) state_in = ST_DRAIN;
         ST_DRAIN: state_in = ST_FEED;
         ST_FEED:  state_in = ST_DIV;
         ST_DIV:   if (dv[SUM_W]) state_in = ST_OUT;
         ST_OUT:   if (rsp_ready) state_in = ST_IDLE;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         image_width_ff   <= 11'd1024;
         image_height_ff  <= 16'd1024;
         channel_count_ff <= 3'd3;
         in_col_ff <= '0; in_row_ff <= '0; in_ch_ff <= '0; in_slot_ff <= '0;
         out_col_ff <= '0; out_row_ff <= '0; out_ch_ff <= '0; out_slot_ff <= '0;
         pending_ff <= '0;
         last_ff    <= 1'b0;
         dy_ff <= '0; dx_ff <= '0;
         rv_ff <= 1'b0; acc_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         acc_ff   <= (state_ff == ST_SCAN);
         rv_ff    <= rd_valid;
         if (cfg_write) begin
            case (csr_index)
               CSR_IMAGE_WIDTH:   image_width_ff   <= csr_data[10:0];
               CSR_IMAGE_HEIGHT:  image_height_ff  <= csr_data;
               CSR_CHANNEL_COUNT: channel_count_ff <= csr_data[2:0];
               default: ;
            endcase
            in_col_ff <= '0; in_row_ff <= '0; in_ch_ff <= '0; in_slot_ff <= '0;
            out_col_ff <= '0; out_row_ff <= '0; out_ch_ff <= '0; out_slot_ff <= '0;
            pending_ff <= '0;
         end
         // input transfer: advance the write position
         if (accept) begin
            pending_ff <= pend_next - LAG_W'(emit);
            last_ff    <= out_last;
            dy_ff <= '0; dx_ff <= '0;
            if (stored) begin
               if (CHC_W'(in_ch_ff) + CHC_W'(1) >= ec) begin
                  in_ch_ff <= '0;
                  if (W_W'(in_col_ff) + W_W'(1) >= ew) begin
                     in_col_ff  <= '0;
                     in_row_ff  <= in_row_ff + 16'd1;
                     in_slot_ff <= (in_slot_ff == SLOT_W'(RING - 1)) ? '0
                                   : in_slot_ff + SLOT_W'(1);
                  end else begin
                     in_col_ff <= in_col_ff + COL_W'(1);
                  end
               end else begin
                  in_ch_ff <= in_ch_ff + CH_W'(1);
               end
            end
         end
         // window walk
         if (state_ff == ST_SCAN) begin
            if (dx_ff == WIN_W'(WIN - 1)) begin
               dx_ff <= '0;
               dy_ff <= dy_ff + WIN_W'(1);
            end else begin
               dx_ff <= dx_ff + WIN_W'(1);
            end
         end
         // result ready: advance output position or restart the frame
         if (state_ff == ST_DIV && dv[SUM_W]) begin
            if (last_ff) begin
               in_col_ff <= '0; in_row_ff <= '0; in_ch_ff <= '0; in_slot_ff <= '0;
               out_col_ff <= '0; out_row_ff <= '0; out_ch_ff <= '0; out_slot_ff <= '0;
               pending_ff <= '0;
            end else if (CHC_W'(out_ch_ff) + CHC_W'(1) >= ec) begin
               out_ch_ff <= '0;
               if (W_W'(out_col_ff) + W_W'(1) >= ew) begin
                  out_col_ff  <= '0;
                  out_row_ff  <= out_row_ff + 16'd1;
                  out_slot_ff <= (out_slot_ff == SLOT_W'(RING - 1)) ? '0
                                 : out_slot_ff + SLOT_W'(1);
               end else begin
                  out_col_ff <= out_col_ff + COL_W'(1);
               end
            end else begin
               out_ch_ff <= out_ch_ff + CH_W'(1);
            end
         end
      end
   end

   // window accumulation and result capture
   always_ff @(posedge clock) begin
      if (accept) begin
         sum_ff <= '0;
         cnt_ff <= '0;
      end else if (acc_ff && rv_ff) begin
         sum_ff <= sum_ff + SUM_W'(rd_data_ff);
         cnt_ff <= cnt_ff + CNT_W'(1);
      end
      if (state_ff == ST_DIV && dv[SUM_W]) begin
         blurred_ff    <= dn[SUM_W][7:0];
         frame_last_ff <= last_ff;
      end
   end

   assign rsp_valid      = (state_ff == ST_OUT);
   assign rsp_blurred    = blurred_ff;
   assign rsp_frame_last = frame_last_ff;

   // checks
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && req_ready)) else $error("input taken while result waits");
   a_chain_end: assert property (@(posedge clock) disable iff (reset)
      dv[SUM_W] |-> state_ff == ST_DIV) else $error("divider result outside wait state");
   a_feed_once: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FEED |=> state_ff == ST_DIV) else $error("feed not followed by wait");
   a_nonzero_count: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FEED |-> cnt_ff != '0) else $error("empty window");

endmodule
